[src/rcfir_pkg.sv]
// Shared types and constants of the row crosstalk FIR.
// Holds the word layouts of both channels, register indexes and commands.
// No dependencies.
package rcfir_pkg;

  // Fixed field widths.
  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int COL_W    = 12;
  localparam int FRAC_W   = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Default geometry.
  localparam int DEF_TAPS       = 7;
  localparam int DEF_TAP_STRIDE = 4;
  localparam int DEF_MAX_PHASES = 8;
  localparam int DEF_MAX_ROW    = 4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT  = 1'b1;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  // Input word.
  typedef struct packed {
    logic                     command;
    logic signed [PIX_W-1:0]  pixel_value;
    logic                     row_end;
    logic [2:0]               coef_phase;
    logic [2:0]               coef_tap;
    logic signed [COEF_W-1:0] coef_value;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic signed [PIX_W-1:0] corrected_pixel;
    logic [COL_W-1:0]        out_column;
    logic                    row_done;
  } out_word_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift_en;
    logic prod_en;
    logic coef_we;
  } cell_ctl_t;

endpackage

[src/row_crosstalk_fir_top.sv]
// Row crosstalk FIR: a chain of tap cells, a registered adder tree and a
// sequencer that counts columns, cycles phases and flushes each row.
// Pipeline: a pixel's result passes the tap registers, the product registers,
// the adder tree levels and the output register. Throughput: one pixel per cycle
// while out_stall_i is low; after a row's last pixel the input stalls while zeros flush the remaining outputs.
// Reset clears counters, valid bits and configuration registers; the delay
// line and the coefficient table are not reset.
module row_crosstalk_fir_top #(
  parameter int TAPS       = rcfir_pkg::DEF_TAPS,
  parameter int TAP_STRIDE = rcfir_pkg::DEF_TAP_STRIDE,
  parameter int MAX_PHASES = rcfir_pkg::DEF_MAX_PHASES,
  parameter int MAX_ROW    = rcfir_pkg::DEF_MAX_ROW
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcfir_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcfir_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rcfir_pkg::in_word_t                  in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rcfir_pkg::out_word_t                 out_o
);

  localparam int Half   = (TAPS - 1) / 2;
  localparam int Fwd    = (TAPS - 1 - Half) * TAP_STRIDE;
  localparam int Levels = $clog2(TAPS);
  localparam int ProdW  = rcfir_pkg::PIX_W + rcfir_pkg::COEF_W;
  localparam int AccW   = ProdW + Levels;
  localparam int PhW    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
  localparam int CntW   = $clog2(MAX_PHASES + 1);
  localparam int ColW   = $clog2(MAX_ROW + Fwd);
  localparam int OW     = $clog2(MAX_ROW);
  localparam int FlW    = $clog2(Fwd + 1);
  localparam int Ns     = Levels + 3;
  localparam int RoundBias = 2 ** rcfir_pkg::FRAC_W - 1;
  localparam logic signed [AccW:0] SatHi = (AccW+1)'(2 ** (rcfir_pkg::PIX_W - 1) - 1);
  localparam logic signed [AccW:0] SatLo = (AccW+1)'(-(2 ** (rcfir_pkg::PIX_W - 1)));

  // Configuration registers.
  logic [2:0] offset_q;
  logic [3:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 3'd0;
      count_q  <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcfir_pkg::CFG_PHASE_OFFSET: offset_q <= cfg_data_i[2:0];
        rcfir_pkg::CFG_PHASE_COUNT:  count_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Effective phase count and the phase of column zero.
  logic [CntW-1:0] count_eff;
  logic [7:0]      start_r;
  logic [PhW-1:0]  start_ph;

  always_comb begin
    if (count_q == 4'd0) begin
      count_eff = CntW'(1);
    end else if (int'(count_q) > MAX_PHASES) begin
      count_eff = CntW'(MAX_PHASES);
    end else begin
      count_eff = CntW'(count_q);
    end
    start_r = 8'(offset_q);
    for (int j = 0; j < 7; j++) begin
      if (start_r >= 8'(count_eff)) begin
        start_r = start_r - 8'(count_eff);
      end
    end
    start_ph = PhW'(start_r);
  end

  // Handshake and pipeline readiness.
  logic [Ns-1:0]  v_q;
  logic [Ns:0]    rdy;
  logic [FlW-1:0] flush_q;
  logic [ColW-1:0] col_q;
  logic [PhW-1:0] ph_q;
  logic flushing, in_acc, is_pix, is_load, virt, step, pix_end, last_virt, emit;

  always_comb begin
    rdy[Ns] = !out_stall_i;
    for (int k = Ns - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign flushing   = (flush_q != '0);
  assign in_stall_o = flushing || !rdy[0];
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_pix     = in_acc && (in_i.command == rcfir_pkg::CMD_PIXEL);
  assign is_load    = in_acc && (in_i.command == rcfir_pkg::CMD_LOAD);
  assign virt       = flushing && rdy[0];
  assign step       = is_pix || virt;
  assign pix_end    = in_i.row_end || (int'(col_q) == MAX_ROW - 1);
  assign last_virt  = virt && (flush_q == FlW'(1));
  assign emit       = (int'(col_q) >= Fwd);

  // Output column and phase of the word produced by this step.
  logic [OW-1:0]  o_cur;
  logic [PhW-1:0] ph_use, ph_next;
  logic [PhW:0]   ph_inc;

  assign o_cur  = OW'(col_q - ColW'(Fwd));
  assign ph_use = (int'(col_q) == Fwd) ? start_ph : ph_q;
  assign ph_inc = {1'b0, ph_use} + (PhW+1)'(1);
  assign ph_next = (int'(ph_inc) >= int'(count_eff)) ? '0 : ph_inc[PhW-1:0];

  // Column counter, flush counter and phase counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      flush_q <= '0;
      ph_q    <= '0;
    end else begin
      if (step) begin
        col_q <= last_virt ? '0 : col_q + ColW'(1);
      end
      if (is_pix && pix_end) begin
        flush_q <= FlW'(Fwd);
      end else if (virt) begin
        flush_q <= flush_q - FlW'(1);
      end
      if (step && emit) begin
        ph_q <= ph_next;
      end
    end
  end

  // Column and row-done tags travel beside the arithmetic.
  logic [OW-1:0] o_q [Ns-1];
  logic          done_q [Ns-1];

  // Tap cells; cell i taps the sample i*TAP_STRIDE steps back.
  logic signed [rcfir_pkg::PIX_W-1:0] chain [TAPS+1];
  logic [TAPS-1:0][ProdW-1:0] prods;

  assign chain[0] = virt ? '0 : in_i.pixel_value;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    rcfir_pkg::cell_ctl_t ctl;
    assign ctl.shift_en = step;
    assign ctl.prod_en  = rdy[1];
    assign ctl.coef_we  = is_load && (int'(in_i.coef_tap) == TAPS - 1 - i)
                          && (int'(in_i.coef_phase) < MAX_PHASES);
    if (i < TAPS - 1) begin : g_mid
      rcfir_cell #(
        .DEPTH(TAP_STRIDE), .MAX_PHASES(MAX_PHASES), .MAX_ROW(MAX_ROW),
        .LIVE_FROM(i * TAP_STRIDE - Fwd)
      ) u_cell (
        .clk_i(clk_i), .ctl_i(ctl), .sample_i(chain[i]), .sample_o(chain[i+1]),
        .coef_waddr_i(PhW'(in_i.coef_phase)), .coef_wdata_i(in_i.coef_value),
        .coef_raddr_i(ph_use), .col_i(o_q[0]), .prod_o(prods[TAPS-1-i])
      );
    end else begin : g_last
      rcfir_cell #(
        .DEPTH(1), .MAX_PHASES(MAX_PHASES), .MAX_ROW(MAX_ROW),
        .LIVE_FROM(i * TAP_STRIDE - Fwd)
      ) u_cell (
        .clk_i(clk_i), .ctl_i(ctl), .sample_i(chain[i]), .sample_o(chain[i+1]),
        .coef_waddr_i(PhW'(in_i.coef_phase)), .coef_wdata_i(in_i.coef_value),
        .coef_raddr_i(ph_use), .col_i(o_q[0]), .prod_o(prods[TAPS-1-i])
      );
    end
  end

  // Adder tree over the products.
  logic signed [AccW-1:0] sum;

  rcfir_sum #(.TAPS(TAPS)) u_sum (
    .clk_i(clk_i), .en_i(rdy[Levels+1:2]), .prod_i(prods), .sum_o(sum)
  );

  // Divide by the Q2.14 scale toward zero, then saturate.
  logic signed [AccW:0] biased, shifted;
  logic signed [rcfir_pkg::PIX_W-1:0] sat;

  always_comb begin
    biased  = (AccW+1)'(sum) + ((sum < 0) ? (AccW+1)'(RoundBias) : '0);
    shifted = biased >>> rcfir_pkg::FRAC_W;
    if (shifted > SatHi) begin
      sat = rcfir_pkg::PIX_W'(SatHi);
    end else if (shifted < SatLo) begin
      sat = rcfir_pkg::PIX_W'(SatLo);
    end else begin
      sat = rcfir_pkg::PIX_W'(shifted);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= step && emit;
      end
      for (int k = 1; k < Ns; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Output word register fed by the tag pipeline and the saturated sum.
  rcfir_pkg::out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      o_q[0]    <= o_cur;
      done_q[0] <= last_virt;
    end
    for (int k = 1; k < Ns - 1; k++) begin
      if (rdy[k]) begin
        o_q[k]    <= o_q[k-1];
        done_q[k] <= done_q[k-1];
      end
    end
    if (rdy[Ns-1]) begin
      out_q.corrected_pixel <= sat;
      out_q.out_column      <= rcfir_pkg::COL_W'(o_q[Ns-2]);
      out_q.row_done        <= done_q[Ns-2];
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = v_q[Ns-1];

  // A row's last pixel starts a flush with the input stalled.
  a_flush_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_pix && pix_end) |=> (flush_q == FlW'(Fwd) && in_stall_o))
    else $error("row end did not start a flush");

  // The last flush step always produces the row's final word.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy[0] && last_virt) |=> (v_q[0] && done_q[0]))
    else $error("final flush step lost its row-done word");

  // A word in the first stage is held while the product stage is blocked.
  a_stage0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !rdy[1]) |=> v_q[0])
    else $error("first stage word dropped under back-pressure");

endmodule

[src/rcfir_cell.sv]
// One tap cell: a segment of the sample delay line, the coefficient bank of
// its tap and a registered multiplier. Depends on rcfir_pkg.
module rcfir_cell #(
  parameter int DEPTH      = rcfir_pkg::DEF_TAP_STRIDE,
  parameter int MAX_PHASES = rcfir_pkg::DEF_MAX_PHASES,
  parameter int MAX_ROW    = rcfir_pkg::DEF_MAX_ROW,
  parameter int LIVE_FROM  = 0
) (
  input  logic                                clk_i,
  input  rcfir_pkg::cell_ctl_t                ctl_i,
  input  logic signed [rcfir_pkg::PIX_W-1:0]  sample_i,
  output logic signed [rcfir_pkg::PIX_W-1:0]  sample_o,
  input  logic [((MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1)-1:0] coef_waddr_i,
  input  logic signed [rcfir_pkg::COEF_W-1:0] coef_wdata_i,
  input  logic [((MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1)-1:0] coef_raddr_i,
  input  logic [$clog2(MAX_ROW)-1:0]          col_i,
  output logic signed [rcfir_pkg::PIX_W+rcfir_pkg::COEF_W-1:0] prod_o
);

  logic signed [rcfir_pkg::PIX_W-1:0]  win_q [DEPTH];
  logic signed [rcfir_pkg::COEF_W-1:0] bank_q [MAX_PHASES];
  logic signed [rcfir_pkg::COEF_W-1:0] coef_q;
  logic signed [rcfir_pkg::PIX_W+rcfir_pkg::COEF_W-1:0] prod_q;
  logic live;

  // Delay line segment; the head register is this cell's tap.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_en) begin
      win_q[0] <= sample_i;
      for (int j = 1; j < DEPTH; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  assign sample_o = win_q[DEPTH-1];

  // Coefficient bank with a registered read for the phase of the next output.
  always_ff @(posedge clk_i) begin
    if (ctl_i.coef_we) begin
      bank_q[coef_waddr_i] <= coef_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_en) begin
      coef_q <= bank_q[coef_raddr_i];
    end
  end

  // The tap sample lies inside the current row once the output column is far
  // enough from the row start.
  assign live = (int'(col_i) >= LIVE_FROM);

  // Registered signed product; a tap before the row start contributes nothing.
  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      if (live) begin
        prod_q <= win_q[0] * coef_q;
      end else begin
        prod_q <= '0;
      end
    end
  end

  assign prod_o = prod_q;

endmodule

[src/rcfir_sum.sv]
// Registered adder tree that sums the tap products, with a register at each level.
// Depends on rcfir_pkg.
module rcfir_sum #(
  parameter int TAPS = rcfir_pkg::DEF_TAPS
) (
  input  logic                                             clk_i,
  input  logic [$clog2(TAPS)-1:0]                          en_i,
  input  logic [TAPS-1:0][rcfir_pkg::PIX_W+rcfir_pkg::COEF_W-1:0] prod_i,
  output logic signed [rcfir_pkg::PIX_W+rcfir_pkg::COEF_W+$clog2(TAPS)-1:0] sum_o
);

  localparam int Levels = $clog2(TAPS);
  localparam int Leaves = 2 ** Levels;
  localparam int AccW   = rcfir_pkg::PIX_W + rcfir_pkg::COEF_W + Levels;

  logic signed [AccW-1:0] leaf [Leaves];
  logic signed [AccW-1:0] node_q [Leaves-1];

  // Leaves: sign-extended products, zero padding up to a power of two.
  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < TAPS) begin : g_prod
      assign leaf[i] = AccW'($signed(prod_i[i]));
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Heap-ordered internal nodes; each level loads with its pipeline stage.
  for (genvar k = 0; k < Leaves - 1; k++) begin : g_node
    localparam int Depth = $clog2(k + 2) - 1;
    localparam int Lvl   = Levels - Depth;
    logic signed [AccW-1:0] lhs, rhs;
    if (2 * k + 1 >= Leaves - 1) begin : g_from_leaf
      assign lhs = leaf[2 * k + 1 - (Leaves - 1)];
      assign rhs = leaf[2 * k + 2 - (Leaves - 1)];
    end else begin : g_from_node
      assign lhs = node_q[2 * k + 1];
      assign rhs = node_q[2 * k + 2];
    end
    always_ff @(posedge clk_i) begin
      if (en_i[Lvl-1]) begin
        node_q[k] <= lhs + rhs;
      end
    end
  end

  assign sum_o = node_q[0];

endmodule
